// ----- sv/gcd3_pkg.sv -----
package gcd3_pkg;

  // operand and result width
  localparam int unsigned DataWidth  = 32;
  // width of the count of common factors of two
  localparam int unsigned ShiftWidth = $clog2(DataWidth);

  // input transaction
  typedef struct packed {
    logic [DataWidth-1:0] first_value;
    logic [DataWidth-1:0] second_value;
    logic [DataWidth-1:0] third_value;
  } operands_t;

  // output transaction
  typedef struct packed {
    logic [DataWidth-1:0] common_divisor;
    logic                 bad_operand;
  } result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // take operands, start first pair
    logic step;    // one binary gcd step
    logic reload;  // first pair done, start pair with third operand
    logic finish;  // second pair done, publish result
    logic fail;    // zero operand, publish error
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic equal;     // working values match, pair finished
    logic any_zero;  // an operand at the input is zero
  } status_t;

endpackage

// ----- sv/gcd_of_three.sv -----
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------
// operands  | start high, busy low  | operands_i (first/second/third_value)
// result    | done_o strobe, 1 cycle| result_o (common_divisor, bad_operand)
//
// binary gcd, one step per cycle in a shared subtract/compare unit: first
// gcd(first, second), then gcd of that with third. Each pair runs halving
// or subtract steps until the working values match, then the pair result
// is taken over; the final result goes through the result register.
// a zero operand gives the error result in the cycle after start.
// reset clears controller state and the strobe; the receiver cannot stall.
module gcd_of_three (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  gcd3_pkg::operands_t operands_i,
  output gcd3_pkg::result_t   result_o,
  output logic                done_o
);

  gcd3_pkg::cmd_t    cmd;
  gcd3_pkg::status_t status;

  // sequencer
  gcd3_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // working registers and step logic
  gcd3_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .operands_i (operands_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_o),
    .done_o     (done_o)
  );

endmodule

// ----- sv/gcd3_ctrl.sv -----
module gcd3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  gcd3_pkg::status_t status_i,
  output gcd3_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPair1 = 2'd1;
  localparam logic [1:0] StPair2 = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (status_i.any_zero) begin
            cmd_o.fail = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = StPair1;
          end
        end
      end
      StPair1: begin
        if (status_i.equal) begin
          cmd_o.reload = 1'b1;
          state_d      = StPair2;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StPair2: begin
        if (status_i.equal) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

// ----- sv/gcd3_dpath.sv -----
module gcd3_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcd3_pkg::operands_t operands_i,
  input  gcd3_pkg::cmd_t      cmd_i,
  output gcd3_pkg::status_t   status_o,
  output gcd3_pkg::result_t   result_o,
  output logic                done_o
);

  localparam int unsigned W = gcd3_pkg::DataWidth;

  logic [W-1:0]                    x_q, x_d, y_q, y_d, c_q, c_d;
  logic [gcd3_pkg::ShiftWidth-1:0] k_q, k_d;
  gcd3_pkg::result_t               res_q, res_d;
  logic                            done_q, done_d;

  logic [W-1:0] diff_xy, diff_yx, pair_gcd;
  logic         x_gt_y;

  // difference and compare for the odd/odd case
  assign diff_xy  = x_q - y_q;
  assign diff_yx  = y_q - x_q;
  assign x_gt_y   = (x_q > y_q);
  // restore common factors of two
  assign pair_gcd = x_q << k_q;

  assign status_o.equal    = (x_q == y_q);
  assign status_o.any_zero = (operands_i.first_value == '0) ||
                             (operands_i.second_value == '0) ||
                             (operands_i.third_value == '0);

  // working registers
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    c_d = c_q;
    k_d = k_q;
    if (cmd_i.load) begin
      x_d = operands_i.first_value;
      y_d = operands_i.second_value;
      c_d = operands_i.third_value;
      k_d = '0;
    end else if (cmd_i.reload) begin
      x_d = pair_gcd;
      y_d = c_q;
      k_d = '0;
    end else if (cmd_i.step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_d = x_q >> 1;
      end else if (!y_q[0]) begin
        y_d = y_q >> 1;
      end else if (x_gt_y) begin
        x_d = diff_xy >> 1;
      end else begin
        y_d = diff_yx >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    c_q <= c_d;
    k_q <= k_d;
  end

  // result register and strobe
  always_comb begin
    res_d  = res_q;
    done_d = 1'b0;
    if (cmd_i.finish) begin
      res_d.common_divisor = pair_gcd;
      res_d.bad_operand    = 1'b0;
      done_d               = 1'b1;
    end else if (cmd_i.fail) begin
      res_d.common_divisor = '0;
      res_d.bad_operand    = 1'b1;
      done_d               = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule
